>>> sv/tld_pkg.sv
`default_nettype none

package tld_pkg;

    // fixed field widths
    localparam int MODE_W    = 3;
    localparam int INDEX_W   = 6;
    localparam int RANK_IN_W = 8;
    localparam int COUNT_W   = 7;
    localparam int TIME_W    = 32;
    localparam int STATUS_W  = 2;

    // config port
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_LEASE_TIMEOUT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT    = 4'd1;

    localparam logic [TIME_W-1:0] LEASE_TIMEOUT_RESET = 32'd10;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK      = 3'd0,
        MODE_ALLOC     = 3'd1,
        MODE_HEARTBEAT = 3'd2,
        MODE_DONE      = 3'd3,
        MODE_ASSIGN    = 3'd4,
        MODE_SWEEP     = 3'd5
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK         = 2'd0,
        STATUS_NONE_FREE  = 2'd1,
        STATUS_BAD_INDEX  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // per-entry verdict from the entry unit
    typedef struct packed {
        logic wr_en;
        logic hit;
    } unit_ctl_t;

endpackage

`default_nettype wire

>>> sv/tld_entry_ram.sv
`default_nettype none

module tld_entry_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 41,
    parameter int ADDR_W = 6
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> sv/tld_entry_unit.sv
`default_nettype none

module tld_entry_unit
    import tld_pkg::*;
#(
    parameter int RANK_BITS = 8,
    parameter int WIDTH     = RANK_BITS + TIME_W + 1
) (
    input  wire mode_t                 op,
    input  wire logic [WIDTH-1:0]      entry_in,
    input  wire logic [RANK_BITS-1:0]  rank,
    input  wire logic [TIME_W-1:0]     now,
    input  wire logic [TIME_W-1:0]     timeout,
    output unit_ctl_t                  ctl,
    output logic      [WIDTH-1:0]      entry_out
);

    // entry word: done flag on top, owner rank, heartbeat time at the bottom
    logic                 done_in;
    logic [RANK_BITS-1:0] owner_in;
    logic [TIME_W-1:0]    hb_in;
    logic [TIME_W-1:0]    age;
    logic                 done_out;
    logic [RANK_BITS-1:0] owner_out;
    logic [TIME_W-1:0]    hb_out;

    assign done_in  = entry_in[WIDTH-1];
    assign owner_in = entry_in[WIDTH-2:TIME_W];
    assign hb_in    = entry_in[TIME_W-1:0];
    assign age      = now - hb_in;

    always_comb
    begin
        ctl       = '0;
        done_out  = done_in;
        owner_out = owner_in;
        hb_out    = hb_in;
        case (op)
            MODE_ALLOC:
            begin
                ctl.hit   = (owner_in == '0) && !done_in;
                ctl.wr_en = ctl.hit;
                owner_out = RANK_BITS'(1);
            end
            MODE_HEARTBEAT:
            begin
                ctl.hit   = (owner_in == rank);
                ctl.wr_en = ctl.hit;
                hb_out    = now;
            end
            MODE_SWEEP:
            begin
                ctl.hit   = (owner_in != '0) && !done_in && (age > timeout);
                ctl.wr_en = ctl.hit;
                owner_out = '0;
            end
            MODE_DONE:
            begin
                ctl.hit   = 1'b1;
                ctl.wr_en = 1'b1;
                done_out  = 1'b1;
            end
            MODE_ASSIGN:
            begin
                ctl.hit   = 1'b1;
                ctl.wr_en = 1'b1;
                owner_out = rank;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    assign entry_out = {done_out, owner_out, hb_out};

endmodule

`default_nettype wire

>>> sv/task_lease_dispatch_table_top.sv
`default_nettype none

// task lease table: MAX_TASKS entries of owner rank, done flag, heartbeat time
// s_* takes one request per item (mode, task_index, node_rank), m_* returns one
// result (status, granted_index) per request, in order
// cfg_* writes lease_timeout (index 0) and task_count (index 1); always ready,
// write only while no request is in flight
// after reset a clearing pass zeroes the entry memory, one entry a cycle;
// s_tready stays low until it ends
// tick, unused modes and bad indices answer without touching the entries;
// mark done and assign owner read then write one entry;
// allocate, heartbeat and sweep walk the live entries through the shared entry
// unit, one per cycle behind the single read port, allocate stopping at the
// first free one
// one request is worked at a time; the next one is taken as soon as the
// result is in the output register, even while m_tready is low
// a stalled receiver holds the result in m_tdata; a finished request then
// waits in the sequencer until the output register frees up
module task_lease_dispatch_table_top
    import tld_pkg::*;
#(
    parameter int MAX_TASKS = 64,
    parameter int RANK_BITS = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // request: [2:0] mode, [8:3] task_index, [16:9] node_rank, [23:17] zero
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [23:0]          s_tdata,
    // result: [1:0] status, [7:2] granted_index
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [7:0]           m_tdata,
    // config write
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [TIME_W-1:0]    cfg_data
);

    localparam int IDX_W   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W   = $clog2(MAX_TASKS + 1);
    localparam int ENTRY_W = RANK_BITS + TIME_W + 1;

    // request fields
    mode_t                in_mode;
    logic [INDEX_W-1:0]   in_index;
    logic [RANK_IN_W-1:0] in_rank;

    assign in_mode  = mode_t'(s_tdata[2:0]);
    assign in_index = s_tdata[8:3];
    assign in_rank  = s_tdata[16:9];

    // sequencer and table state
    state_t               state_reg,      state_next;
    mode_t                op_reg,         op_next;
    logic [RANK_BITS-1:0] rank_reg,       rank_next;
    logic [CNT_W-1:0]     addr_reg,       addr_next;
    logic [CNT_W-1:0]     end_reg,        end_next;
    logic                 pend_reg,       pend_next;
    logic [IDX_W-1:0]     pend_addr_reg,  pend_addr_next;
    status_t              status_reg,     status_next;
    logic [INDEX_W-1:0]   granted_reg,    granted_next;
    logic [TIME_W-1:0]    now_reg,        now_next;
    logic [TIME_W-1:0]    timeout_reg,    timeout_next;
    logic [COUNT_W-1:0]   count_reg,      count_next;
    logic                 m_tvalid_reg,   m_tvalid_next;
    logic [7:0]           m_tdata_reg,    m_tdata_next;

    // memory and entry unit hookup
    logic                 ram_wr_en;
    logic [IDX_W-1:0]     ram_wr_addr;
    logic [ENTRY_W-1:0]   ram_wr_data;
    logic [IDX_W-1:0]     ram_rd_addr;
    logic [ENTRY_W-1:0]   ram_rd_data;
    unit_ctl_t            unit_ctl;
    logic [ENTRY_W-1:0]   unit_entry;

    logic [CNT_W-1:0]     live_n;
    logic                 idx_ok;
    logic                 issue;

    // task_count above MAX_TASKS acts as MAX_TASKS
    always_comb
    begin
        if (32'(count_reg) > 32'(MAX_TASKS))
        begin
            live_n = CNT_W'(MAX_TASKS);
        end
        else
        begin
            live_n = CNT_W'(count_reg);
        end
    end

    assign idx_ok = (32'(in_index) < 32'(live_n));
    assign issue  = (addr_reg < end_reg);

    tld_entry_ram #(
        .DEPTH  (MAX_TASKS),
        .WIDTH  (ENTRY_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    tld_entry_unit #(
        .RANK_BITS (RANK_BITS),
        .WIDTH     (ENTRY_W)
    ) u_unit (
        .op        (op_reg),
        .entry_in  (ram_rd_data),
        .rank      (rank_reg),
        .now       (now_reg),
        .timeout   (timeout_reg),
        .ctl       (unit_ctl),
        .entry_out (unit_entry)
    );

    // config writes, taken in any state
    assign cfg_ready = 1'b1;

    always_comb
    begin
        timeout_next = timeout_reg;
        count_next   = count_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LEASE_TIMEOUT: timeout_next = cfg_data;
                CFG_TASK_COUNT:    count_next   = cfg_data[COUNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        rank_next      = rank_reg;
        addr_next      = addr_reg;
        end_next       = end_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        status_next    = status_reg;
        granted_next   = granted_reg;
        now_next       = now_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;

        s_tready       = 1'b0;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = pend_addr_reg;
        ram_wr_data    = unit_entry;
        ram_rd_addr    = addr_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_CLEAR:
            begin
                // zero the entries one at a time, in address order, after reset
                ram_wr_en   = 1'b1;
                ram_wr_addr = addr_reg[IDX_W-1:0];
                ram_wr_data = '0;
                if (addr_reg == CNT_W'(MAX_TASKS - 1))
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    op_next      = in_mode;
                    rank_next    = RANK_BITS'(in_rank);
                    pend_next    = 1'b0;
                    granted_next = '0;
                    status_next  = STATUS_OK;
                    addr_next    = '0;
                    end_next     = live_n;
                    state_next   = ST_FINISH;
                    case (in_mode)
                        MODE_TICK:
                        begin
                            now_next = now_reg + 1'b1;
                        end
                        MODE_ALLOC:
                        begin
                            status_next = STATUS_NONE_FREE;
                            state_next  = ST_SCAN;
                        end
                        MODE_HEARTBEAT, MODE_SWEEP:
                        begin
                            state_next = ST_SCAN;
                        end
                        MODE_DONE, MODE_ASSIGN:
                        begin
                            if (idx_ok)
                            begin
                                // one-entry walk: read then write back
                                addr_next  = CNT_W'(in_index);
                                end_next   = CNT_W'(32'(in_index) + 32'd1);
                                state_next = ST_SCAN;
                            end
                            else
                            begin
                                status_next = STATUS_BAD_INDEX;
                            end
                        end
                        default:
                        begin
                            status_next = STATUS_OK;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // read entry addr while the unit judges the one read last cycle
                if (issue)
                begin
                    addr_next      = addr_reg + 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = addr_reg[IDX_W-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end

                ram_wr_en = pend_reg && unit_ctl.wr_en;

                if (pend_reg && (op_reg == MODE_ALLOC) && unit_ctl.hit)
                begin
                    status_next  = STATUS_OK;
                    granted_next = INDEX_W'(pend_addr_reg);
                    pend_next    = 1'b0;
                    state_next   = ST_FINISH;
                end
                else if (!issue && !pend_reg)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {granted_reg, status_reg};
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            addr_reg     <= '0;
            end_reg      <= '0;
            pend_reg     <= 1'b0;
            now_reg      <= '0;
            timeout_reg  <= LEASE_TIMEOUT_RESET;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            end_reg      <= end_next;
            pend_reg     <= pend_next;
            now_reg      <= now_next;
            timeout_reg  <= timeout_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        rank_reg      <= rank_next;
        pend_addr_reg <= pend_addr_next;
        status_reg    <= status_next;
        granted_reg   <= granted_next;
        m_tdata_reg   <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

>>> sv/tld_checker.sv
`default_nettype none

module tld_checker
    import tld_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // s_tready drops in the cycle after a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // only known status codes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[1:0] <= STATUS_BAD_INDEX)
        else $error("bad status code");

    // a granted index comes only with ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] != STATUS_OK |-> m_tdata[7:2] == '0)
        else $error("index granted on failure");

endmodule

bind task_lease_dispatch_table_top tld_checker u_tld_checker (.*);

`default_nettype wire
